[rtl/core/spg_pkg.sv]
// Shared types and constants for the scan path generator.
package spg_pkg;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 136;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [16:0] MAX_POINTS = 17'd65536;

   localparam logic [1:0] MODE_SPIRAL = 2'd1;
   localparam logic [1:0] MODE_SERP   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_PATH_MODE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_POINT_COUNT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_LENGTH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_COUNT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_X      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_Y      = 3'd5;

   typedef struct packed {
      logic [1:0]  path_mode;
      logic [16:0] point_count;
      logic [15:0] row_length;
      logic [15:0] row_count;
      logic [23:0] step_x;
      logic [23:0] step_y;
   } cfg_type;

   typedef struct packed {
      logic        status;
      logic [15:0] point_index;
      logic [16:0] grid_x;
      logic [16:0] grid_y;
      logic        last;
   } point_type;

endpackage

[rtl/core/scan_path_generator.sv]
// Top level of the scan path generator.
//
// Each request beat carries one command in req_tdata bit 0: 1 restarts the
// path and returns point 0, 0 returns the next point. Every request beat
// produces exactly one response beat. rsp_tuser is the status: 0 for a valid
// point, 1 when the path is disabled, invalid or exhausted, in which case
// all data fields are zero and the path does not move. rsp_tlast marks the
// final point of the path.
// A request beat is held in an input register; the next-point logic and the
// step multipliers then fill the output register, which drives response
// valid. One beat per cycle is sustained while the receiver takes beats.
// When the receiver stalls, the output register holds its beat and the
// input register takes one more beat before req_tready falls.
// Reset empties both registers, loads the register defaults and starts the
// path at point 0. Configuration writes restart the path; the user must make
// them only while no beat is in flight, as the block does not enforce this.
module scan_path_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [spg_pkg::REQ_DATA_W-1:0]     req_tdata,   // restart, zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // point_index, grid_x, grid_y, pos_x, pos_y, zero fill
   output logic [spg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,   // status
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [spg_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [spg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import spg_pkg::*;

   cfg_type   cfg;
   point_type point;
   logic      cfg_wr;
   logic      in_valid_ff, in_valid_in;
   logic      restart_ff;
   logic      out_valid_ff, out_valid_in;
   logic      advance, req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         restart_ff <= req_tdata[0];
      end
   end

   spg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_wr    (cfg_wr)
   );

   spg_path u_path (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cfg_wr  (cfg_wr),
      .step_en (advance),
      .restart (restart_ff),
      .point   (point)
   );

   spg_result u_result (
      .clock  (clock),
      .load   (advance),
      .point  (point),
      .step_x (cfg.step_x),
      .step_y (cfg.step_y),
      .tdata  (rsp_tdata),
      .tuser  (rsp_tuser),
      .tlast  (rsp_tlast)
   );

   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("no-point beat carries data or last");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output register is empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed beat did not reach the output register");

endmodule

[rtl/core/spg_csr.sv]
// Configuration registers of the scan path generator.
module spg_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [spg_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [spg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output spg_pkg::cfg_type                     cfg,
   output logic                                 cfg_wr
);
   import spg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    hit;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr_we) begin
         hit = 1'b1;
         unique case (csr_index)
            REG_PATH_MODE:   cfg_in.path_mode   = csr_wdata[1:0];
            REG_POINT_COUNT: cfg_in.point_count = csr_wdata[16:0];
            REG_ROW_LENGTH:  cfg_in.row_length  = csr_wdata[15:0];
            REG_ROW_COUNT:   cfg_in.row_count   = csr_wdata[15:0];
            REG_STEP_X:      cfg_in.step_x      = csr_wdata;
            REG_STEP_Y:      cfg_in.step_y      = csr_wdata;
            default:         hit                = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.path_mode   <= 2'd0;
         cfg_ff.point_count <= 17'd0;
         cfg_ff.row_length  <= 16'd1;
         cfg_ff.row_count   <= 16'd1;
         cfg_ff.step_x      <= 24'd256;
         cfg_ff.step_y      <= 24'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg    = cfg_ff;
   assign cfg_wr = hit;

endmodule

[rtl/core/spg_path.sv]
// Path state and next-point stepping for spiral and serpentine scans.
module spg_path (
   input  logic                clock,
   input  logic                reset,
   input  spg_pkg::cfg_type    cfg,
   input  logic                cfg_wr,
   input  logic                step_en,
   input  logic                restart,
   output spg_pkg::point_type  point
);
   import spg_pkg::*;

   logic        fresh_ff;
   logic [16:0] idx_ff, idx_in;
   logic [16:0] x_ff, x_in;
   logic [16:0] y_ff, y_in;
   logic [1:0]  sdir_ff, sdir_in;
   logic [1:0]  serp_ff, serp_in;
   logic [15:0] col_ff, col_in;

   logic        fresh;
   logic [16:0] idx_e, x_e, y_e;
   logic [1:0]  sdir_e, serp_e, dir_t;
   logic [15:0] col_e;
   logic [16:0] count;
   logic        path_ok, no_point;
   logic [17:0] xs, ys, ax, ay;
   logic        diag, quad;
   logic [16:0] col_inc;

   function automatic logic [16:0] dir_dx(input logic [1:0] d);
      unique case (d)
         2'd0:    dir_dx = 17'd1;
         2'd2:    dir_dx = '1;
         default: dir_dx = 17'd0;
      endcase
   endfunction

   function automatic logic [16:0] dir_dy(input logic [1:0] d);
      unique case (d)
         2'd1:    dir_dy = 17'd1;
         2'd3:    dir_dy = '1;
         default: dir_dy = 17'd0;
      endcase
   endfunction

   always_comb begin
      fresh  = fresh_ff | restart;
      idx_e  = fresh ? 17'd0 : idx_ff;
      x_e    = fresh ? 17'd0 : x_ff;
      y_e    = fresh ? 17'd0 : y_ff;
      sdir_e = fresh ? 2'd0 : sdir_ff;
      serp_e = fresh ? ((cfg.row_length <= 16'd1) ? 2'd0 : 2'd1) : serp_ff;
      col_e  = fresh ? 16'd0 : col_ff;

      count    = (cfg.point_count > MAX_POINTS) ? MAX_POINTS : cfg.point_count;
      path_ok  = (cfg.path_mode == MODE_SPIRAL) ||
                 (cfg.path_mode == MODE_SERP && cfg.row_length != 16'd0 &&
                  cfg.row_count != 16'd0);
      no_point = !path_ok || (idx_e >= count);

      point.status      = no_point;
      point.point_index = no_point ? 16'd0 : idx_e[15:0];
      point.grid_x      = no_point ? 17'd0 : x_e;
      point.grid_y      = no_point ? 17'd0 : y_e;
      point.last        = !no_point && (idx_e + 17'd1 == count);

      xs    = {x_e[16], x_e};
      ys    = {y_e[16], y_e};
      ax    = xs[17] ? (18'd0 - xs) : xs;
      ay    = ys[17] ? (18'd0 - ys) : ys;
      diag  = (ax == ay);
      quad  = !x_e[16] && (y_e[16] || y_e == 17'd0);
      dir_t = sdir_e + 2'd1;

      col_inc = {1'b0, col_e} + 17'd1;

      idx_in  = idx_e;
      x_in    = x_e;
      y_in    = y_e;
      sdir_in = sdir_e;
      serp_in = serp_e;
      col_in  = col_e;

      if (!no_point) begin
         idx_in = idx_e + 17'd1;
         if (cfg.path_mode == MODE_SPIRAL) begin
            if (diag) begin
               sdir_in = dir_t;
               if (quad) begin
                  x_in = x_e + 17'd1;
               end else begin
                  x_in = x_e + dir_dx(dir_t);
                  y_in = y_e + dir_dy(dir_t);
               end
            end else begin
               x_in = x_e + dir_dx(sdir_e);
               y_in = y_e + dir_dy(sdir_e);
            end
         end else begin
            if (col_inc >= {1'b0, cfg.row_length}) begin
               col_in  = 16'd0;
               serp_in = 2'd0 - serp_e;
               y_in    = y_e + 17'd1;
            end else begin
               col_in = col_inc[15:0];
               x_in   = x_e + {{15{serp_e[1]}}, serp_e};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
         idx_ff   <= 17'd0;
         x_ff     <= 17'd0;
         y_ff     <= 17'd0;
         sdir_ff  <= 2'd0;
         serp_ff  <= 2'd0;
         col_ff   <= 16'd0;
      end else if (cfg_wr) begin
         fresh_ff <= 1'b1;
      end else if (step_en) begin
         fresh_ff <= 1'b0;
         idx_ff   <= idx_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         sdir_ff  <= sdir_in;
         serp_ff  <= serp_in;
         col_ff   <= col_in;
      end
   end

endmodule

[rtl/core/spg_result.sv]
// Result register with step scaling of the grid coordinates.
module spg_result (
   input  logic                                clock,
   input  logic                                load,
   input  spg_pkg::point_type                  point,
   input  logic [23:0]                         step_x,
   input  logic [23:0]                         step_y,
   output logic [spg_pkg::RSP_DATA_W-1:0]      tdata,
   output logic                                tuser,
   output logic                                tlast
);
   import spg_pkg::*;

   logic signed [40:0]      pos_x, pos_y;
   logic [RSP_DATA_W-1:0]   data_ff, data_in;
   logic                    user_ff, last_ff;

   always_comb begin
      pos_x   = $signed(point.grid_x) * $signed({1'b0, step_x});
      pos_y   = $signed(point.grid_y) * $signed({1'b0, step_y});
      data_in = {4'd0, pos_y, pos_x, point.grid_y, point.grid_x, point.point_index};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= point.status;
         last_ff <= point.last;
      end
   end

   assign tdata = data_ff;
   assign tuser = user_ff;
   assign tlast = last_ff;

endmodule
